// File: rtl/labeled_voxel_centroid_stats_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the labeled voxel centroid statistics unit
// Concurrent checks on clk, disabled while rst is high; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef LABELED_VOXEL_CENTROID_STATS_UNIT_ASSERT_SVH
`define LABELED_VOXEL_CENTROID_STATS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LVCS_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lvcs assertion failed");
`define LVCS_ASSERT_NEXT(name, trig, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error("lvcs assertion failed");
`else
`define LVCS_ASSERT(name, prop)
`define LVCS_ASSERT_NEXT(name, trig, prop)
`endif
`endif

// File: rtl/lvcs_pkg.sv
// ----------------------------------------------------------------------------
// lvcs_pkg
// Shared widths, table entry type, arithmetic unit command and helpers.
// ----------------------------------------------------------------------------
package lvcs_pkg;

  localparam int LABEL_COUNT = 1024;
  localparam int LBL_W       = $clog2(LABEL_COUNT);
  localparam int CNT_W       = 30;
  localparam int SUM_W       = 40;
  localparam int POS_W       = 10;
  localparam int DIM_W       = 11;
  localparam int SP_W        = 32;
  localparam int OUT_W       = 48;
  localparam int ACC_W       = 128;
  localparam int DVD_W       = 72;
  localparam int CFG_IDX_W   = 3;

  localparam logic [DIM_W-1:0] MAX_DIM = 11'd1024;

  // Input operation codes
  localparam logic [1:0] OP_ACCUM = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLNS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPZ   = 3'd5;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum_col;
    logic [SUM_W-1:0] sum_row;
    logic [SUM_W-1:0] sum_plane;
  } tbl_entry_t;

  localparam int ENTRY_W = $bits(tbl_entry_t);

  // Arithmetic unit modes
  localparam logic MDU_MUL = 1'b0;
  localparam logic MDU_DIV = 1'b1;

  typedef struct packed {
    logic start;
    logic mode;
  } mdu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_stat_t;

  function automatic logic [OUT_W-1:0] sat48(input logic [ACC_W-1:0] v);
    sat48 = (|v[ACC_W-1:OUT_W]) ? '1 : v[OUT_W-1:0];
  endfunction

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      eff_dim = DIM_W'(1);
    end else if (v > MAX_DIM) begin
      eff_dim = MAX_DIM;
    end else begin
      eff_dim = v;
    end
  endfunction

endpackage

// File: rtl/labeled_voxel_centroid_stats_unit.sv
// Requests are handled one at a time: an accumulate reads the label's entry, then
// writes it back in S_ACC; a clear sweeps the whole label table before S_IDLE.
// The read time is set by the shared adder: six 32-step multiplies, three 72-step
// divides. Reset (synchronous) restores registers and runs a clearing pass over all
// 1024 entries of the label table, during which no request is taken.
// ----------------------------------------------------------------------------
// labeled_voxel_centroid_stats_unit
// Per-label voxel count, centroid and volume over a raster-ordered volume.
// ----------------------------------------------------------------------------
`include "labeled_voxel_centroid_stats_unit_assert.svh"

module labeled_voxel_centroid_stats_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lvcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lvcs_pkg::SP_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        op,
  input  logic [lvcs_pkg::LBL_W-1:0]        label,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lvcs_pkg::CNT_W-1:0]        voxel_count,
  output logic [lvcs_pkg::OUT_W-1:0]        centroid_x,
  output logic [lvcs_pkg::OUT_W-1:0]        centroid_y,
  output logic [lvcs_pkg::OUT_W-1:0]        centroid_z,
  output logic [lvcs_pkg::OUT_W-1:0]        region_volume,
  output logic                              empty_region
);
  import lvcs_pkg::*;

  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ACC    = 3'd2;
  localparam logic [2:0] S_RDL    = 3'd3;
  localparam logic [2:0] S_LAUNCH = 3'd4;
  localparam logic [2:0] S_WAIT   = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  localparam logic [3:0] J_MX  = 4'd0;
  localparam logic [3:0] J_DX  = 4'd1;
  localparam logic [3:0] J_MY  = 4'd2;
  localparam logic [3:0] J_DY  = 4'd3;
  localparam logic [3:0] J_MZ  = 4'd4;
  localparam logic [3:0] J_DZ  = 4'd5;
  localparam logic [3:0] J_VXY = 4'd6;
  localparam logic [3:0] J_VCN = 4'd7;
  localparam logic [3:0] J_VZ  = 4'd8;

  logic [2:0]       state;
  logic [3:0]       job;
  logic [LBL_W-1:0] clr_addr;
  logic [LBL_W-1:0] lbl;

  logic [DIM_W-1:0] cols_per_row, rows_per_plane, plane_count;
  logic [SP_W-1:0]  spacing_x, spacing_y, spacing_z;
  logic [POS_W-1:0] cur_col, cur_row, cur_plane;
  logic [POS_W-1:0] pos_col, pos_row, pos_plane;

  tbl_entry_t       ent;
  tbl_entry_t       rdata;
  tbl_entry_t       wdata;
  logic             tbl_we;
  logic [LBL_W-1:0] waddr;
  logic             in_acc;

  logic [ACC_W-1:0] tmp;
  logic [OUT_W-1:0] cx, cy, cz, vol;
  logic             empty;

  mdu_cmd_t         mcmd;
  mdu_stat_t        mstat;
  logic [ACC_W-1:0] mopa;
  logic [SP_W-1:0]  mopb;
  logic [ACC_W-1:0] mres;

  logic             flat;
  logic             out_free;
  logic [SUM_W:0]   add_col, add_row, add_plane;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign flat     = (plane_count <= DIM_W'(1));
  assign out_free = !out_valid || !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_per_row   <= DIM_W'(1);
      rows_per_plane <= DIM_W'(1);
      plane_count    <= DIM_W'(1);
      spacing_x      <= SP_W'(65536);
      spacing_y      <= SP_W'(65536);
      spacing_z      <= SP_W'(65536);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COLS: cols_per_row   <= cfg_data[DIM_W-1:0];
        REG_ROWS: rows_per_plane <= cfg_data[DIM_W-1:0];
        REG_PLNS: plane_count    <= cfg_data[DIM_W-1:0];
        REG_SPX:  spacing_x      <= cfg_data;
        REG_SPY:  spacing_y      <= cfg_data;
        REG_SPZ:  spacing_z      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Table update: clear during S_CLR, else saturating count and sums
  always_comb begin
    add_col   = {1'b0, rdata.sum_col}   + (SUM_W+1)'(pos_col);
    add_row   = {1'b0, rdata.sum_row}   + (SUM_W+1)'(pos_row);
    add_plane = {1'b0, rdata.sum_plane} + (SUM_W+1)'(pos_plane);
    if (state == S_CLR) begin
      tbl_we = 1'b1;
      waddr  = clr_addr;
      wdata  = '0;
    end else begin
      tbl_we = (state == S_ACC);
      waddr  = lbl;
      wdata.cnt       = (rdata.cnt == CNT_MAX) ? CNT_MAX : rdata.cnt + CNT_W'(1);
      wdata.sum_col   = add_col[SUM_W]   ? SUM_MAX : add_col[SUM_W-1:0];
      wdata.sum_row   = add_row[SUM_W]   ? SUM_MAX : add_row[SUM_W-1:0];
      wdata.sum_plane = add_plane[SUM_W] ? SUM_MAX : add_plane[SUM_W-1:0];
    end
  end

  lvcs_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (in_acc),
    .raddr (label),
    .rdata (rdata)
  );

  // Operand select for the shared arithmetic unit
  always_comb begin
    mcmd.start = (state == S_LAUNCH);
    mcmd.mode  = MDU_MUL;
    mopa       = '0;
    mopb       = '0;
    case (job)
      J_MX: begin
        mopa = ACC_W'(ent.sum_col);
        mopb = spacing_x;
      end
      J_MY: begin
        mopa = ACC_W'(ent.sum_row);
        mopb = spacing_y;
      end
      J_MZ: begin
        mopa = ACC_W'(ent.sum_plane);
        mopb = spacing_z;
      end
      J_DX, J_DY, J_DZ: begin
        mcmd.mode = MDU_DIV;
        mopa      = tmp;
        mopb      = SP_W'(ent.cnt);
      end
      J_VXY: begin
        mopa = ACC_W'(spacing_x);
        mopb = spacing_y;
      end
      J_VCN: begin
        mopa = tmp;
        mopb = SP_W'(ent.cnt);
      end
      J_VZ: begin
        mopa = tmp;
        mopb = spacing_z;
      end
      default: ;
    endcase
  end

  lvcs_mdu u_mdu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (mcmd),
    .opa    (mopa),
    .opb    (mopb),
    .stat   (mstat),
    .result (mres)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      cur_plane <= '0;
      job       <= J_MX;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + LBL_W'(1);
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            lbl <= label;
            unique case (op)
              OP_ACCUM: begin
                state     <= S_ACC;
                pos_col   <= cur_col;
                pos_row   <= cur_row;
                pos_plane <= cur_plane;
                // advance the raster position
                if (DIM_W'(cur_col) + DIM_W'(1) >= eff_dim(cols_per_row)) begin
                  cur_col <= '0;
                  if (DIM_W'(cur_row) + DIM_W'(1) >= eff_dim(rows_per_plane)) begin
                    cur_row <= '0;
                    if (DIM_W'(cur_plane) + DIM_W'(1) >= eff_dim(plane_count)) begin
                      cur_plane <= '0;
                    end else begin
                      cur_plane <= cur_plane + POS_W'(1);
                    end
                  end else begin
                    cur_row <= cur_row + POS_W'(1);
                  end
                end else begin
                  cur_col <= cur_col + POS_W'(1);
                end
              end
              OP_READ: begin
                state <= S_RDL;
              end
              OP_CLEAR: begin
                state     <= S_CLR;
                clr_addr  <= '0;
                cur_col   <= '0;
                cur_row   <= '0;
                cur_plane <= '0;
              end
              OP_NOP: ;
              default: ;
            endcase
          end
        end
        S_ACC: begin
          state <= S_IDLE;
        end
        S_RDL: begin
          ent <= rdata;
          job <= J_MX;
          if (rdata.cnt == '0) begin
            cx    <= '0;
            cy    <= '0;
            cz    <= '0;
            vol   <= '0;
            empty <= 1'b1;
            state <= S_FIN;
          end else begin
            empty <= 1'b0;
            state <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (mstat.done) begin
            // capture the finished job
            case (job)
              J_DX:    cx <= sat48(mres);
              J_DY:    cy <= sat48(mres);
              J_DZ:    cz <= flat ? '0 : sat48(mres);
              J_VCN: begin
                tmp <= mres;
                vol <= sat48(mres >> 16);
              end
              J_VZ: begin
                if (!flat) begin
                  vol <= sat48(mres >> 48);
                end
              end
              default: tmp <= mres;
            endcase
            if (job == J_VZ) begin
              state <= S_FIN;
            end else begin
              job   <= job + 4'd1;
              state <= S_LAUNCH;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

  // Output register: load when the slot is free, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      voxel_count   <= ent.cnt;
      centroid_x    <= cx;
      centroid_y    <= cy;
      centroid_z    <= cz;
      region_volume <= vol;
      empty_region  <= empty;
    end
  end

  `LVCS_ASSERT(a_we_state, tbl_we |-> (state == S_ACC || state == S_CLR))
  `LVCS_ASSERT(a_empty_zero, (out_valid && empty_region) |-> (voxel_count == '0 && centroid_x == '0 && region_volume == '0))
  `LVCS_ASSERT_NEXT(a_done_adv, (state == S_WAIT && mstat.done), (state == S_LAUNCH || state == S_FIN))
  `LVCS_ASSERT(a_fin_idle_mdu, (state == S_FIN || state == S_IDLE) |-> !mstat.busy)

endmodule

// File: rtl/lvcs_table.sv
// ----------------------------------------------------------------------------
// lvcs_table
// Per-label statistics memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lvcs_table (
  input  logic                          clk,
  input  logic                          we,
  input  logic [lvcs_pkg::LBL_W-1:0]    waddr,
  input  lvcs_pkg::tbl_entry_t          wdata,
  input  logic                          re,
  input  logic [lvcs_pkg::LBL_W-1:0]    raddr,
  output lvcs_pkg::tbl_entry_t          rdata
);
  import lvcs_pkg::*;

  tbl_entry_t mem [LABEL_COUNT];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lvcs_mdu.sv
// ----------------------------------------------------------------------------
// lvcs_mdu
// Shared shift-add multiplier and restoring divider around one 128-bit adder.
// ----------------------------------------------------------------------------
module lvcs_mdu (
  input  logic                        clk,
  input  logic                        rst,
  input  lvcs_pkg::mdu_cmd_t          cmd,
  input  logic [lvcs_pkg::ACC_W-1:0]  opa,
  input  logic [lvcs_pkg::SP_W-1:0]   opb,
  output lvcs_pkg::mdu_stat_t         stat,
  output logic [lvcs_pkg::ACC_W-1:0]  result
);
  import lvcs_pkg::*;

  localparam int STEP_W = $clog2(DVD_W);

  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  mcand;
  logic [SP_W-1:0]   mplier;
  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic              mode;
  logic              busy;
  logic              done;

  logic [ACC_W-1:0]  add_a;
  logic [ACC_W-1:0]  add_b;
  logic [ACC_W:0]    sum;
  logic              ge;
  logic              last;

  // Shared adder: accumulate for multiply, trial subtract for divide
  always_comb begin
    if (mode == MDU_DIV) begin
      add_a = {{(ACC_W-CNT_W-1){1'b0}}, rem, mcand[DVD_W-1]};
      add_b = ~{{(ACC_W-CNT_W){1'b0}}, mplier[CNT_W-1:0]};
    end else begin
      add_a = acc;
      add_b = mplier[0] ? mcand : '0;
    end
    sum  = {1'b0, add_a} + {1'b0, add_b} + (ACC_W+1)'(mode == MDU_DIV);
    ge   = sum[ACC_W];
    last = (mode == MDU_DIV) ? (step == STEP_W'(DVD_W-1)) : (step == STEP_W'(SP_W-1));
  end

  // Control: start, count steps, pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: one multiply or divide step per cycle while busy
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode   <= cmd.mode;
      acc    <= '0;
      mcand  <= opa;
      mplier <= opb;
      rem    <= '0;
      step   <= '0;
    end else if (busy) begin
      step  <= step + STEP_W'(1);
      mcand <= {mcand[ACC_W-2:0], 1'b0};
      if (mode == MDU_DIV) begin
        acc <= {acc[ACC_W-2:0], ge};
        rem <= ge ? sum[CNT_W-1:0] : {rem[CNT_W-2:0], mcand[DVD_W-1]};
      end else begin
        acc    <= sum[ACC_W-1:0];
        mplier <= {1'b0, mplier[SP_W-1:1]};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = acc;

endmodule
